### src/countdown_timer_with_alarm_top_assert.svh
// assertion macros for the countdown timer top level
`ifndef COUNTDOWN_TIMER_WITH_ALARM_TOP_ASSERT_SVH
`define COUNTDOWN_TIMER_WITH_ALARM_TOP_ASSERT_SVH

// same-cycle implication, reset masked
`define CDT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define CDT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cdt_pkg.sv
// shared types, constants and codes for the countdown timer
`timescale 1ns / 1ps
`default_nettype none
package cdt_pkg;

	localparam int SEC_W       = 13;
	localparam int MIN_W       = 7;
	localparam int MAXMIN_W    = 8;
	localparam int SLOT_W      = 6;
	localparam int PT_W        = 11;
	localparam int MS_W        = 32;
	localparam int LP_W        = 16;
	localparam int DRAG_W      = 8;
	localparam int PAT_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int DEF_PATTERN_SLOTS = 32;
	localparam int DEF_MAX_MINUTES   = 90;
	localparam int SEC_PER_MIN       = 60;
	localparam int SEC_MAX           = 8191;

	localparam logic [SEC_W-1:0] RST_SECONDS = SEC_W'(1500);

	typedef enum logic [2:0] {
		OP_SEC_TICK  = 3'd0,
		OP_SLOT_TICK = 3'd1,
		OP_PRESS     = 3'd2,
		OP_MOVE      = 3'd3,
		OP_RELEASE   = 3'd4,
		OP_DIAL      = 3'd5,
		OP_PRESET    = 3'd6
	} cdt_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESET_FIRST  = 3'd0,
		CFG_PRESET_SECOND = 3'd1,
		CFG_PRESET_THIRD  = 3'd2,
		CFG_LONG_PRESS    = 3'd3,
		CFG_DRAG_LIMIT    = 3'd4,
		CFG_PATTERN       = 3'd5,
		CFG_AWAKE_MARGIN  = 3'd6
	} cdt_cfg_idx_t;

	typedef struct packed {
		logic [MIN_W-1:0]  preset_first;
		logic [MIN_W-1:0]  preset_second;
		logic [MIN_W-1:0]  preset_third;
		logic [LP_W-1:0]   long_press_ms;
		logic [DRAG_W-1:0] drag_limit;
		logic [PAT_W-1:0]  alarm_pattern;
		logic [SEC_W-1:0]  awake_margin;
	} cdt_cfg_t;

	typedef struct packed {
		logic [2:0]              opcode;
		logic signed [PT_W-1:0]  point_x;
		logic signed [PT_W-1:0]  point_y;
		logic [MS_W-1:0]         now_ms;
		logic [MIN_W-1:0]        dial_minutes;
		logic [1:0]              preset_index;
	} cdt_evt_t;

	typedef struct packed {
		logic [SEC_W-1:0]        total_time;
		logic [SEC_W-1:0]        time_left;
		logic                    run;
		logic                    ring;
		logic [SLOT_W-1:0]       slot;
		logic                    tone;
		logic                    awake;
		logic signed [PT_W-1:0]  press_x;
		logic signed [PT_W-1:0]  press_y;
		logic [MS_W-1:0]         press_stamp;
		logic                    drag;
		logic                    long_hold;
	} cdt_state_t;

	typedef struct packed {
		logic [SEC_W-1:0] seconds_left;
		logic [SEC_W-1:0] seconds_total;
		logic             is_running;
		logic             is_ringing;
		logic             tone_on;
		logic             screen_hold;
		logic             screen_wake;
	} cdt_res_t;

endpackage
`default_nettype wire

### src/cdt_evt_if.sv
// event channel interface
`timescale 1ns / 1ps
`default_nettype none
interface cdt_evt_if import cdt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [2:0]             opcode;
	logic signed [PT_W-1:0] point_x;
	logic signed [PT_W-1:0] point_y;
	logic [MS_W-1:0]        now_ms;
	logic [MIN_W-1:0]       dial_minutes;
	logic [1:0]             preset_index;

	modport source (output valid, opcode, point_x, point_y, now_ms, dial_minutes,
		preset_index, input ready);
	modport sink (input valid, opcode, point_x, point_y, now_ms, dial_minutes,
		preset_index, output ready);
endinterface
`default_nettype wire

### src/cdt_res_if.sv
// result channel interface
`timescale 1ns / 1ps
`default_nettype none
interface cdt_res_if import cdt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEC_W-1:0] seconds_left;
	logic [SEC_W-1:0] seconds_total;
	logic             is_running;
	logic             is_ringing;
	logic             tone_on;
	logic             screen_hold;
	logic             screen_wake;

	modport source (output valid, seconds_left, seconds_total, is_running, is_ringing,
		tone_on, screen_hold, screen_wake, input ready);
	modport sink (input valid, seconds_left, seconds_total, is_running, is_ringing,
		tone_on, screen_hold, screen_wake, output ready);
endinterface
`default_nettype wire

### src/cdt_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps
`default_nettype none
module cdt_cfg_regs import cdt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cdt_cfg_t                   cfg
);

	cdt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preset_first  <= MIN_W'(5);
			cfg_q.preset_second <= MIN_W'(15);
			cfg_q.preset_third  <= MIN_W'(25);
			cfg_q.long_press_ms <= LP_W'(600);
			cfg_q.drag_limit    <= DRAG_W'(8);
			cfg_q.alarm_pattern <= PAT_W'(32'h0505_0505);
			cfg_q.awake_margin  <= SEC_W'(60);
		end else if (cfg_we) begin
			case (cdt_cfg_idx_t'(cfg_idx))
				CFG_PRESET_FIRST:  cfg_q.preset_first  <= cfg_wdata[MIN_W-1:0];
				CFG_PRESET_SECOND: cfg_q.preset_second <= cfg_wdata[MIN_W-1:0];
				CFG_PRESET_THIRD:  cfg_q.preset_third  <= cfg_wdata[MIN_W-1:0];
				CFG_LONG_PRESS:    cfg_q.long_press_ms <= cfg_wdata[LP_W-1:0];
				CFG_DRAG_LIMIT:    cfg_q.drag_limit    <= cfg_wdata[DRAG_W-1:0];
				CFG_PATTERN:       cfg_q.alarm_pattern <= cfg_wdata[PAT_W-1:0];
				CFG_AWAKE_MARGIN:  cfg_q.awake_margin  <= cfg_wdata[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### src/cdt_core.sv
// timer state and single-pass event update
`timescale 1ns / 1ps
`default_nettype none
module cdt_core import cdt_pkg::*; #(
	parameter int PATTERN_SLOTS = DEF_PATTERN_SLOTS,
	parameter int MAX_MINUTES   = DEF_MAX_MINUTES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  cdt_evt_t  evt,
	input  cdt_cfg_t  cfg,
	output cdt_res_t  res,
	output cdt_state_t st
);

	cdt_state_t st_q;
	cdt_state_t nxt;
	logic       wake;

	logic [SEC_W-1:0]        load_sec;
	logic [MIN_W-1:0]        preset_min;
	logic [SLOT_W-1:0]       slot_w;
	logic signed [PT_W:0]    dx;
	logic signed [PT_W:0]    dy;
	logic [PT_W:0]           adx;
	logic [PT_W:0]           ady;
	logic [MS_W-1:0]         elapsed;
	logic                    drag_n;

	function automatic logic [SEC_W-1:0] min_to_sec(input logic [MIN_W-1:0] m);
		logic [MAXMIN_W-1:0] mc;
		logic [SEC_W:0]      s;
		mc = {1'b0, m};
		if (mc == '0)
			mc = MAXMIN_W'(1);
		if (mc > MAXMIN_W'(MAX_MINUTES))
			mc = MAXMIN_W'(MAX_MINUTES);
		s = (SEC_W+1)'(mc * SEC_PER_MIN);
		if (s > (SEC_W+1)'(SEC_MAX))
			s = (SEC_W+1)'(SEC_MAX);
		return s[SEC_W-1:0];
	endfunction

	always_comb begin
		case (evt.preset_index)
			2'd0:    preset_min = cfg.preset_first;
			2'd1:    preset_min = cfg.preset_second;
			default: preset_min = cfg.preset_third;
		endcase
	end

	assign load_sec = min_to_sec((cdt_op_t'(evt.opcode) == OP_DIAL) ? evt.dial_minutes
		: preset_min);

	assign slot_w = ({1'b0, st_q.slot} >= (SLOT_W+1)'(PATTERN_SLOTS)) ? '0 : st_q.slot;

	assign dx      = {evt.point_x[PT_W-1], evt.point_x} - {st_q.press_x[PT_W-1], st_q.press_x};
	assign dy      = {evt.point_y[PT_W-1], evt.point_y} - {st_q.press_y[PT_W-1], st_q.press_y};
	assign adx     = dx[PT_W] ? (PT_W+1)'(-dx) : (PT_W+1)'(dx);
	assign ady     = dy[PT_W] ? (PT_W+1)'(-dy) : (PT_W+1)'(dy);
	assign elapsed = evt.now_ms - st_q.press_stamp;
	assign drag_n  = st_q.drag || (adx > (PT_W+1)'(cfg.drag_limit))
		|| (ady > (PT_W+1)'(cfg.drag_limit));

	always_comb begin
		nxt  = st_q;
		wake = 1'b0;
		case (cdt_op_t'(evt.opcode))
			OP_SEC_TICK: begin
				if (st_q.run && st_q.time_left != '0) begin
					if ({1'b0, st_q.time_left} == ({1'b0, cfg.awake_margin} + (SEC_W+1)'(1)))
						nxt.awake = 1'b1;
					nxt.time_left = st_q.time_left - SEC_W'(1);
					if (nxt.time_left == '0) begin
						nxt.run   = 1'b0;
						nxt.awake = 1'b1;
						if (!st_q.ring) begin
							nxt.ring = 1'b1;
							nxt.slot = '0;
							wake     = 1'b1;
						end
					end
				end
			end
			OP_SLOT_TICK: begin
				if (st_q.ring) begin
					nxt.tone = !slot_w[SLOT_W-1] && cfg.alarm_pattern[slot_w[SLOT_W-2:0]];
					nxt.slot = slot_w + SLOT_W'(1);
				end else begin
					nxt.tone = 1'b0;
				end
			end
			OP_PRESS: begin
				nxt.press_x     = evt.point_x;
				nxt.press_y     = evt.point_y;
				nxt.press_stamp = evt.now_ms;
				nxt.drag        = 1'b0;
				nxt.long_hold   = 1'b0;
			end
			OP_MOVE: begin
				nxt.drag = drag_n;
				if (!drag_n && !st_q.long_hold && elapsed >= MS_W'(cfg.long_press_ms)) begin
					nxt.long_hold = 1'b1;
					nxt.run       = 1'b0;
					nxt.time_left = st_q.total_time;
					nxt.ring      = 1'b0;
					nxt.tone      = 1'b0;
					nxt.slot      = '0;
					nxt.awake     = 1'b0;
				end
			end
			OP_RELEASE: begin
				if (!st_q.drag && !st_q.long_hold) begin
					if (st_q.time_left == '0) begin
						nxt.time_left = st_q.total_time;
						nxt.ring      = 1'b0;
						nxt.tone      = 1'b0;
						nxt.slot      = '0;
					end else begin
						nxt.run = !st_q.run;
					end
					nxt.awake = nxt.run && (nxt.time_left <= cfg.awake_margin);
				end
			end
			OP_DIAL: begin
				if (!st_q.run) begin
					nxt.total_time = load_sec;
					nxt.time_left  = load_sec;
					nxt.ring       = 1'b0;
					nxt.tone       = 1'b0;
					nxt.slot       = '0;
				end
			end
			OP_PRESET: begin
				if (evt.preset_index != 2'd3) begin
					nxt.total_time = load_sec;
					nxt.time_left  = load_sec;
					nxt.ring       = 1'b0;
					nxt.tone       = 1'b0;
					nxt.slot       = '0;
					nxt.run        = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.total_time  <= RST_SECONDS;
			st_q.time_left   <= RST_SECONDS;
			st_q.run         <= 1'b0;
			st_q.ring        <= 1'b0;
			st_q.slot        <= '0;
			st_q.tone        <= 1'b0;
			st_q.awake       <= 1'b0;
			st_q.press_x     <= '0;
			st_q.press_y     <= '0;
			st_q.press_stamp <= '0;
			st_q.drag        <= 1'b0;
			st_q.long_hold   <= 1'b0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	assign res.seconds_left  = nxt.time_left;
	assign res.seconds_total = nxt.total_time;
	assign res.is_running    = nxt.run;
	assign res.is_ringing    = nxt.ring;
	assign res.tone_on       = nxt.tone;
	assign res.screen_hold   = nxt.awake;
	assign res.screen_wake   = wake;
	assign st                = st_q;

endmodule
`default_nettype wire

### src/countdown_timer_with_alarm_top.sv
// countdown timer with alarm, top level
//
//  channel   dir  handshake     payload
//  evt       in   valid/ready   opcode, point_x, point_y, now_ms, dial_minutes, preset_index
//  res       out  valid/ready   seconds_left .. screen_wake, one per event
//  cfg_*     in   write enable  cfg_idx selects register, cfg_wdata value
//
//  event transaction to result passes the input register, then the update and result register
//  one event per cycle sustained while results are taken; the timer state is read and written in the update stage
//  a stalled result holds the update stage; the input register still frees while the
//  update stage can move
//  reset restores the timer state and configuration to their defaults and clears both valid flags
`timescale 1ns / 1ps
`default_nettype none
`include "countdown_timer_with_alarm_top_assert.svh"
module countdown_timer_with_alarm_top import cdt_pkg::*; #(
	parameter int PATTERN_SLOTS = DEF_PATTERN_SLOTS,
	parameter int MAX_MINUTES   = DEF_MAX_MINUTES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	cdt_evt_if.sink                    evt,
	cdt_res_if.source                  res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cdt_cfg_t   cfg;
	cdt_evt_t   evt_s1;
	logic       vld_s1;
	cdt_res_t   res_comb;
	cdt_res_t   res_q;
	logic       res_vld_q;
	cdt_state_t st;
	logic       adv;
	logic       fire;
	logic       evt_fire;

	assign adv      = !res_vld_q || res.ready;
	assign fire     = vld_s1 && adv;
	assign evt.ready = !vld_s1 || adv;
	assign evt_fire = evt.valid && evt.ready;

	cdt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (evt.ready)
			vld_s1 <= evt.valid;
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			evt_s1.opcode       <= evt.opcode;
			evt_s1.point_x      <= evt.point_x;
			evt_s1.point_y      <= evt.point_y;
			evt_s1.now_ms       <= evt.now_ms;
			evt_s1.dial_minutes <= evt.dial_minutes;
			evt_s1.preset_index <= evt.preset_index;
		end
	end

	cdt_core #(
		.PATTERN_SLOTS (PATTERN_SLOTS),
		.MAX_MINUTES   (MAX_MINUTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res_comb),
		.st     (st)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (adv)
			res_vld_q <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_comb;
	end

	assign res.valid         = res_vld_q;
	assign res.seconds_left  = res_q.seconds_left;
	assign res.seconds_total = res_q.seconds_total;
	assign res.is_running    = res_q.is_running;
	assign res.is_ringing    = res_q.is_ringing;
	assign res.tone_on       = res_q.tone_on;
	assign res.screen_hold   = res_q.screen_hold;
	assign res.screen_wake   = res_q.screen_wake;

	`CDT_ASSERT_IMP(a_ring_stopped, st.ring, !st.run && st.time_left == '0, "ringing while counting")
	`CDT_ASSERT_IMP(a_left_le_total, 1'b1, st.time_left <= st.total_time, "time left above total")
	`CDT_ASSERT_IMP(a_wake_ring, res_vld_q && res_q.screen_wake,
		res_q.is_ringing && !res_q.is_running && res_q.screen_hold, "wake pulse without alarm")
	`CDT_ASSERT_NXT(a_evt_staged, evt_fire, vld_s1, "accepted event not staged")

endmodule
`default_nettype wire
